/* design/nns_pkg.sv */
// nns_pkg: shared types, register indexes and the pixel repacking function
// for the nearest-neighbor rgb555 scaler. No dependencies.

package nns_pkg;

  localparam int unsigned COLOR_W  = 15;
  localparam int unsigned INDEX_W  = 15;
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned OUT_X_W  = 9;
  localparam int unsigned OUT_Y_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [INDEX_W-1:0]    src_index_t;
  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [OUT_X_W-1:0]    out_x_t;
  typedef logic [OUT_Y_W-1:0]    out_y_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_OUT_WIDTH  = 2'd2,
    CFG_OUT_HEIGHT = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_FETCH = 1'b1
  } action_t;

  // blue to the top, red to the bottom, one zero bit, then swap the bytes
  function automatic pixel_t convert_pixel(input color_t c);
    pixel_t v;
    v = {c[4:0], c[9:5], c[14:10], 1'b0};
    return {v[7:0], v[15:8]};
  endfunction

endpackage

/* design/nns_req_if.sv */
// nns_req_if: request channel of the scaler (valid/ready plus payload).
// Depends on nns_pkg.

interface nns_req_if;
  import nns_pkg::*;

  logic       valid;
  logic       ready;
  logic       action;
  src_index_t src_index;
  color_t     color;

  modport source (output valid, action, src_index, color, input ready);
  modport sink   (input valid, action, src_index, color, output ready);
endinterface

/* design/nns_rsp_if.sv */
// nns_rsp_if: result channel of the scaler (valid/ready plus payload).
// Depends on nns_pkg.

interface nns_rsp_if;
  import nns_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;
  out_x_t out_x;
  out_y_t out_y;
  logic   frame_last;

  modport source (output valid, pixel, out_x, out_y, frame_last, input ready);
  modport sink   (input valid, pixel, out_x, out_y, frame_last, output ready);
endinterface

/* design/nearest_neighbor_scaler_rgb555.sv */
// nearest_neighbor_scaler_rgb555: top level, frame store, raster stepping,
// read stage and result register. Depends on nns_pkg, nns_req_if, nns_rsp_if.
//
// Usage:
//   req carries one request per handshake. action = write stores color at
//   src_index (ignored when src_index is beyond the store); action = fetch
//   returns the next pixel of the output frame in raster order on rsp, with
//   its column, row and an end-of-frame flag. Writes give no result.
//   cfg writes one of four size registers when cfg_we is high; any write
//   restarts the output raster at (0,0). Write only while idle.
// Timing:
//   one request per cycle sustained while rsp.ready stays high. A fetch is
//   registered into the read stage, with the frame store read, when it is
//   taken, then into the result register, which drives rsp until the
//   result is taken.
// Reset:
//   rst restores the default sizes (160x144 to 266x240), zeroes the raster
//   counters and empties the pipeline. The frame store is not cleared.
// Stall:
//   with rsp.ready low the result holds; one more fetch may sit in the read
//   stage, after which req.ready drops until the result is taken.

module nearest_neighbor_scaler_rgb555 #(
  parameter int unsigned FRAME_DEPTH = 32768
) (
  input  logic                      clk,
  input  logic                      rst,
  nns_req_if.sink                   req,
  nns_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  nns_pkg::cfg_index_t       cfg_index,
  input  nns_pkg::cfg_data_t        cfg_data
);
  import nns_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(FRAME_DEPTH);

  // size registers
  logic [8:0] src_width, src_height, out_width;
  logic [7:0] out_height;

  // raster state
  logic [8:0]    col_counter, col_counter_next;
  logic [7:0]    row_counter, row_counter_next;
  logic [8:0]    col_accum, col_accum_next;
  logic [7:0]    row_accum, row_accum_next;
  logic [7:0]    src_col, src_col_next;
  logic [7:0]    src_row, src_row_next;
  logic [AW-1:0] row_base, row_base_next;   // src_row * sw modulo depth

  // effective sizes
  logic [8:0] sw, sh, ow, oh;

  always_comb begin
    sw = (src_width == 9'd0) ? 9'd1 : ((src_width > 9'd256) ? 9'd256 : src_width);
    sh = (src_height == 9'd0) ? 9'd1 : ((src_height > 9'd256) ? 9'd256 : src_height);
    ow = (out_width < sw) ? sw : out_width;
    oh = ({1'b0, out_height} < sh) ? sh : {1'b0, out_height};
  end

  // pipeline control
  logic s1_valid, out_valid;
  logic s1_move, in_take, fetch_take, write_take;

  assign s1_move    = !out_valid || rsp.ready;
  assign req.ready  = !s1_valid || s1_move;
  assign in_take    = req.valid && req.ready;
  assign fetch_take = in_take && (req.action == ACT_FETCH);
  assign write_take = in_take && (req.action == ACT_WRITE)
                      && (32'(req.src_index) < FRAME_DEPTH);

  // read address and end-of-frame flag
  logic [AW:0]   addr_sum;
  logic [AW-1:0] rd_addr;
  logic [9:0]    col_plus;
  logic [8:0]    row_plus;
  logic          col_wrap, row_wrap, last;

  always_comb begin
    addr_sum = (AW+1)'(row_base) + (AW+1)'(src_col);
    rd_addr  = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : AW'(addr_sum);
    col_plus = 10'(col_counter) + 10'd1;
    row_plus = 9'(row_counter) + 9'd1;
    col_wrap = !(col_plus < 10'(ow));
    row_wrap = !(row_plus < oh);
    last     = (col_plus == 10'(ow)) && (row_plus == oh);
  end

  // raster stepping
  logic [9:0]  col_sum;
  logic [8:0]  row_sum;
  logic [AW:0] base_sum;

  always_comb begin
    col_sum  = 10'(col_accum) + 10'(sw);
    row_sum  = 9'(row_accum) + sh;
    base_sum = (AW+1)'(row_base) + (AW+1)'(sw);

    col_counter_next = col_counter;
    row_counter_next = row_counter;
    col_accum_next   = col_accum;
    row_accum_next   = row_accum;
    src_col_next     = src_col;
    src_row_next     = src_row;
    row_base_next    = row_base;

    if (!col_wrap) begin
      col_counter_next = 9'(col_plus);
      if (col_sum >= 10'(ow)) begin
        col_accum_next = 9'(col_sum - 10'(ow));
        src_col_next   = src_col + 8'd1;
      end else begin
        col_accum_next = 9'(col_sum);
      end
    end else begin
      col_counter_next = '0;
      col_accum_next   = '0;
      src_col_next     = '0;
      if (!row_wrap) begin
        row_counter_next = 8'(row_plus);
        if (row_sum >= oh) begin
          row_accum_next = 8'(row_sum - oh);
          src_row_next   = src_row + 8'd1;
          row_base_next  = (base_sum >= DEPTH_W) ? AW'(base_sum - DEPTH_W)
                                                 : AW'(base_sum);
        end else begin
          row_accum_next = 8'(row_sum);
        end
      end else begin
        row_counter_next = '0;
        row_accum_next   = '0;
        src_row_next     = '0;
        row_base_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= 9'd160;
      src_height  <= 9'd144;
      out_width   <= 9'd266;
      out_height  <= 8'd240;
      col_counter <= '0;
      row_counter <= '0;
      col_accum   <= '0;
      row_accum   <= '0;
      src_col     <= '0;
      src_row     <= '0;
      row_base    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data;
        CFG_SRC_HEIGHT: src_height <= cfg_data;
        CFG_OUT_WIDTH:  out_width  <= cfg_data;
        CFG_OUT_HEIGHT: out_height <= cfg_data[7:0];
        default: ;
      endcase
      col_counter <= '0;
      row_counter <= '0;
      col_accum   <= '0;
      row_accum   <= '0;
      src_col     <= '0;
      src_row     <= '0;
      row_base    <= '0;
    end else if (fetch_take) begin
      col_counter <= col_counter_next;
      row_counter <= row_counter_next;
      col_accum   <= col_accum_next;
      row_accum   <= row_accum_next;
      src_col     <= src_col_next;
      src_row     <= src_row_next;
      row_base    <= row_base_next;
    end
  end

  // frame store with registered read
  color_t frame_store [FRAME_DEPTH];
  color_t rd_data;

  always_ff @(posedge clk) begin
    if (write_take) begin
      frame_store[AW'(req.src_index)] <= req.color;
    end
    if (fetch_take) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // read stage
  out_x_t s1_x;
  out_y_t s1_y;
  logic   s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fetch_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_take) begin
      s1_x    <= col_counter;
      s1_y    <= row_counter;
      s1_last <= last;
    end
  end

  // result register
  pixel_t out_pixel;
  out_x_t out_x_r;
  out_y_t out_y_r;
  logic   out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_pixel <= convert_pixel(rd_data);
      out_x_r   <= s1_x;
      out_y_r   <= s1_y;
      out_last  <= s1_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pixel      = out_pixel;
  assign rsp.out_x      = out_x_r;
  assign rsp.out_y      = out_y_r;
  assign rsp.frame_last = out_last;

endmodule

/* dv/nearest_neighbor_scaler_rgb555_tb.sv */
`timescale 1ns / 1ps
// nearest_neighbor_scaler_rgb555_tb: self-checking bench for the rgb555 nearest-neighbor scaler.
// Drives write and fetch requests plus the size registers, predicts each fetched pixel
// and checks it in order. Depends on nns_pkg, nns_req_if, nns_rsp_if and the scaler top.

module nearest_neighbor_scaler_rgb555_tb;
  import nns_pkg::*;

  localparam int unsigned STORE_DEPTH   = 32768;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    pixel_t pixel;
    out_x_t out_x;
    out_y_t out_y;
    logic   frame_last;
  } scaled_pixel_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  nns_req_if req_ch ();
  nns_rsp_if rsp_ch ();

  nearest_neighbor_scaler_rgb555 #(
    .FRAME_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // size registers as last written and the raster position of the output frame
  cfg_data_t   src_w_reg;
  cfg_data_t   src_h_reg;
  cfg_data_t   out_w_reg;
  out_y_t      out_h_reg;
  int unsigned raster_col;
  int unsigned raster_row;
  int unsigned col_acc;
  int unsigned row_acc;
  int unsigned tap_col;
  int unsigned tap_row;

  color_t store_shadow  [STORE_DEPTH];
  bit     store_written [STORE_DEPTH];

  scaled_pixel_t pending_pixels [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            no_idle = 1'b0;
  int unsigned   rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_src(cfg_data_t v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_w();
    int unsigned sw;
    sw = clamp_src(src_w_reg);
    return (32'(out_w_reg) < sw) ? sw : 32'(out_w_reg);
  endfunction

  function automatic int unsigned frame_h();
    int unsigned sh;
    sh = clamp_src(src_h_reg);
    return (32'(out_h_reg) < sh) ? sh : 32'(out_h_reg);
  endfunction

  function automatic int unsigned tap_address();
    return (tap_row * clamp_src(src_w_reg) + tap_col) % STORE_DEPTH;
  endfunction

  function automatic pixel_t swap_rgb555(color_t c);
    logic [15:0] word;
    word = (16'(c[4:0]) << 11) | (16'(c[9:5]) << 6) | (16'(c[14:10]) << 1);
    return {word[7:0], word[15:8]};
  endfunction

  function automatic void restart_raster();
    raster_col = 0;
    raster_row = 0;
    col_acc    = 0;
    row_acc    = 0;
    tap_col    = 0;
    tap_row    = 0;
  endfunction

  function automatic void predict_fetch();
    int unsigned   sw;
    int unsigned   sh;
    int unsigned   ow;
    int unsigned   oh;
    scaled_pixel_t want;
    sw = clamp_src(src_w_reg);
    sh = clamp_src(src_h_reg);
    ow = frame_w();
    oh = frame_h();
    want.pixel      = swap_rgb555(store_shadow[tap_address()]);
    want.out_x      = out_x_t'(raster_col);
    want.out_y      = out_y_t'(raster_row);
    want.frame_last = (raster_col + 1 == ow) && (raster_row + 1 == oh);
    pending_pixels.push_back(want);
    // step the raster; the accumulators track the source position without a divide
    if (raster_col + 1 < ow) begin
      raster_col++;
      col_acc += sw;
      if (col_acc >= ow) begin
        col_acc -= ow;
        tap_col++;
      end
    end else begin
      raster_col = 0;
      col_acc    = 0;
      tap_col    = 0;
      if (raster_row + 1 < oh) begin
        raster_row++;
        row_acc += sh;
        if (row_acc >= oh) begin
          row_acc -= oh;
          tap_row++;
        end
      end else begin
        raster_row = 0;
        row_acc    = 0;
        tap_row    = 0;
      end
    end
  endfunction

  // receiver side: random stalls, or a long hold when a test asks for one
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        rx_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    scaled_pixel_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("%0t: unexpected pixel %h x %0d y %0d last %b", $time,
                   rsp_ch.pixel, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.frame_last);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_ch.pixel !== want.pixel || rsp_ch.out_x !== want.out_x ||
            rsp_ch.out_y !== want.out_y || rsp_ch.frame_last !== want.frame_last) begin
          if (mismatch_count < REPORT_MAX)
            $display("%0t: expected pixel %h x %0d y %0d last %b, got %h x %0d y %0d last %b",
                     $time, want.pixel, want.out_x, want.out_y, want.frame_last,
                     rsp_ch.pixel, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.frame_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(action_t act, src_index_t idx, color_t col);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.src_index <= idx;
    req_ch.color     <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (act == ACT_WRITE) begin
      store_shadow[idx]  = col;
      store_written[idx] = 1'b1;
    end else begin
      predict_fetch();
    end
    @(negedge clk);
  endtask

  // a fetch never reads an entry that was never written: fill it first
  task automatic fetch_pixels(int unsigned count);
    int unsigned addr;
    repeat (count) begin
      addr = tap_address();
      if (!store_written[addr])
        send_request(ACT_WRITE, src_index_t'(addr), color_t'($urandom));
      send_request(ACT_FETCH, src_index_t'($urandom), color_t'($urandom));
    end
  endtask

  task automatic write_random_pixel();
    int unsigned span;
    span = clamp_src(src_w_reg) * clamp_src(src_h_reg);
    if (span > STORE_DEPTH) span = STORE_DEPTH;
    if ($urandom_range(1))
      send_request(ACT_WRITE, src_index_t'($urandom_range(span - 1)), color_t'($urandom));
    else
      send_request(ACT_WRITE, src_index_t'($urandom), color_t'($urandom));
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // a trailing write request may still be in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_size_reg(cfg_index_t idx, cfg_data_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = value;
      CFG_SRC_HEIGHT: src_h_reg = value;
      CFG_OUT_WIDTH:  out_w_reg = value;
      CFG_OUT_HEIGHT: out_h_reg = value[7:0];
      default: ;
    endcase
    restart_raster();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(cfg_data_t sw, cfg_data_t sh, cfg_data_t ow, cfg_data_t oh);
    wait_results_drained();
    write_size_reg(CFG_SRC_WIDTH, sw);
    write_size_reg(CFG_SRC_HEIGHT, sh);
    write_size_reg(CFG_OUT_WIDTH, ow);
    write_size_reg(CFG_OUT_HEIGHT, oh);
  endtask

  task automatic test_reset_defaults();
    color_t corner_colors [6] = '{15'h0000, 15'h7FFF, 15'h7C00, 15'h03E0, 15'h001F, 15'h5555};
    for (int i = 0; i < 6; i++)
      send_request(ACT_WRITE, src_index_t'(i), corner_colors[i]);
    send_request(ACT_WRITE, 15'h7FFF, 15'h2AAA);
    fetch_pixels(8);
  endtask

  task automatic test_degenerate_sizes();
    // zero sizes give a 1x1 frame: every pixel closes the frame
    set_geometry(9'd0, 9'd0, 9'd0, 9'd0);
    fetch_pixels(3);
    // oversized source saturates to 256 and drags the output up with it
    set_geometry(9'd511, 9'd300, 9'd0, 9'd0);
    fetch_pixels(4);
  endtask

  task automatic test_clamped_output();
    set_geometry(9'd5, 9'd3, 9'd2, 9'd1);
    fetch_pixels(17);
  endtask

  task automatic test_restart_on_write();
    set_geometry(9'd7, 9'd4, 9'd13, 9'd9);
    fetch_pixels(10);
    wait_results_drained();
    write_size_reg(CFG_OUT_WIDTH, 9'd13);
    fetch_pixels(4);
    wait_results_drained();
    write_size_reg(CFG_SRC_HEIGHT, 9'd4);
    fetch_pixels(3);
  endtask

  // output height of 256 only fits when the source is 256 rows
  task automatic test_tall_frame();
    set_geometry(9'd1, 9'd256, 9'd1, 9'd0);
    fetch_pixels(260);
  endtask

  task automatic test_backpressure();
    set_geometry(9'd4, 9'd3, 9'd9, 9'd7);
    no_idle = 1'b1;
    rx_hold = 120;
    fetch_pixels(40);
    no_idle = 1'b0;
    wait_results_drained();
    fetch_pixels(30);
  endtask

  task automatic test_random_phases();
    int unsigned sw;
    int unsigned sh;
    for (int phase = 0; phase < 8; phase++) begin
      no_idle = (phase == 3);
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
      case (phase)
        6: set_geometry(9'd511, 9'd0, 9'd511, 9'd255);
        7: set_geometry(9'd0, 9'd511, 9'd0, 9'd0);
        default: set_geometry(cfg_data_t'(sw), cfg_data_t'(sh),
                              cfg_data_t'($urandom_range(0, sw + 10)),
                              cfg_data_t'($urandom_range(0, sh + 8)));
      endcase
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(99) < 75)
          fetch_pixels(1);
        else
          write_random_pixel();
      end
    end
    no_idle = 1'b0;
  endtask

  // full 256-wide rows with no idling on either side, across one row boundary
  task automatic test_wide_rows();
    set_geometry(9'd256, 9'd256, 9'd256, 9'd255);
    no_idle = 1'b1;
    fetch_pixels(300);
    no_idle = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SRC_WIDTH;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_WRITE;
    req_ch.src_index = '0;
    req_ch.color     = '0;
    src_w_reg        = 9'd160;
    src_h_reg        = 9'd144;
    out_w_reg        = 9'd266;
    out_h_reg        = 8'd240;
    restart_raster();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_degenerate_sizes();
    test_clamped_output();
    test_restart_on_write();
    test_tall_frame();
    test_backpressure();
    test_random_phases();
    test_wide_rows();

    wait_results_drained();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
